>>> hdl/lzwc_pkg.sv
// Package for the LZW byte compressor: codes, defaults, FSM state types and the
// packer command struct. No dependencies.
`default_nettype none

package lzwc_pkg;

  // Reserved codes and starting width
  localparam int unsigned CODE_CLEAR = 256;
  localparam int unsigned CODE_END   = 257;
  localparam int unsigned CODE_FIRST = 258;
  localparam int unsigned WIDTH_MIN  = 9;

  // Default sizes
  localparam int unsigned DICT_ENTRIES_DEF = 4096;
  localparam int unsigned HASH_SLOTS_DEF   = 8192;

  // Widest code the largest legal dictionary can produce, and width field size
  localparam int unsigned CODE_W_MAX = 16;
  localparam int unsigned CW_W       = 5;

  typedef enum logic [1:0] {
    KIND_CODE,
    KIND_DONE
  } pack_kind_t;

  // One command from the controller to the bit packer
  typedef struct packed {
    pack_kind_t            kind;
    logic [CODE_W_MAX-1:0] code;
    logic [CW_W-1:0]       width;
    logic                  last;
  } pack_cmd_t;

  typedef enum logic [3:0] {
    C_SWEEP,
    C_IDLE,
    C_PROBE,
    C_CODE1,
    C_CODE2,
    C_CODE3,
    C_CODE4,
    C_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    P_IDLE,
    P_PUSH,
    P_FLUSH
  } pack_state_t;

endpackage

`default_nettype wire

>>> hdl/lzw_byte_compressor.sv
// LZW byte compressor, 9-bit codes growing to log2(DICT_ENTRIES) bits, packed
// LSB first. An item is one input byte. It is accepted, then the hash store is
// probed (one read of the hash store per probe), then each code sent is handed
// to the packer, which pushes out each output byte it fills and then returns to
// idle, and last the item is closed; a stalled output holds this up. After reset,
// after a dictionary restart and after the final byte the hash store is swept
// clear, slot by slot, and no byte is accepted during the sweep.
// Depends on lzwc_pkg, lzwc_hash_ram, lzwc_ctrl and lzwc_packer.
`default_nettype none

module lzw_byte_compressor #(
  parameter int unsigned DICT_ENTRIES = lzwc_pkg::DICT_ENTRIES_DEF,
  parameter int unsigned HASH_SLOTS   = lzwc_pkg::HASH_SLOTS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       final_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      code_byte,
  output logic            run_end,
  output logic            stream_end
);
  import lzwc_pkg::*;

  localparam int unsigned DW = $clog2(DICT_ENTRIES);
  localparam int unsigned HW = $clog2(HASH_SLOTS);
  localparam int unsigned EW = 2 * DW + 9;

  pack_cmd_t     cmd;
  logic          cmd_valid, cmd_ready;
  logic          ram_we;
  logic [HW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  lzwc_hash_ram #(
    .DEPTH(HASH_SLOTS),
    .WIDTH(EW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lzwc_ctrl #(
    .DICT_ENTRIES(DICT_ENTRIES),
    .HASH_SLOTS  (HASH_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .final_byte(final_byte),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  lzwc_packer u_pack (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_byte (code_byte),
    .run_end   (run_end),
    .stream_end(stream_end)
  );

endmodule

`default_nettype wire

>>> hdl/lzwc_hash_ram.sv
// Hash slot store: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module lzwc_hash_ram #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned WIDTH = 33
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/lzwc_ctrl.sv
// Controller: hash probing, dictionary update, code sequencing and hash sweep.
// Depends on lzwc_pkg; drives lzwc_hash_ram and lzwc_packer.
`default_nettype none

module lzwc_ctrl #(
  parameter int unsigned DICT_ENTRIES = 4096,
  parameter int unsigned HASH_SLOTS   = 8192
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [7:0]                data_byte,
  input  wire logic                      final_byte,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  output logic                           cmd_valid,
  input  wire logic                      cmd_ready,
  output lzwc_pkg::pack_cmd_t            cmd,
  output logic                           ram_we,
  output logic [$clog2(HASH_SLOTS)-1:0]  ram_waddr,
  output logic [2*$clog2(DICT_ENTRIES)+8:0] ram_wdata,
  output logic [$clog2(HASH_SLOTS)-1:0]  ram_raddr,
  input  wire logic [2*$clog2(DICT_ENTRIES)+8:0] ram_rdata
);
  import lzwc_pkg::*;

  localparam int unsigned DW = $clog2(DICT_ENTRIES);
  localparam int unsigned HW = $clog2(HASH_SLOTS);
  localparam int unsigned NW = DW + 1;
  localparam int unsigned EW = 2 * DW + 9;

  ctrl_state_t state, state_next;

  logic [DW-1:0]   pending;
  logic            started;
  logic [NW-1:0]   next_code;
  logic [CW_W-1:0] code_width;
  logic [7:0]      k_r;
  logic            last_r;
  logic [HW-1:0]   probe_addr;
  logic [HW-1:0]   probe_cnt;
  logic [DW-1:0]   send_code;
  logic [CW_W-1:0] send_cw;
  logic            need_clr;
  logic            need_sweep;
  logic [HW-1:0]   sweep_addr;

  // Hash of pending string and incoming byte
  logic [31:0] hash_wide;
  logic [HW-1:0] hash0;
  assign hash_wide = (32'(pending) << 8) ^ 32'(data_byte);
  assign hash0     = hash_wide[HW-1:0];

  // Slot fields and probe outcome
  logic          slot_valid;
  logic [DW-1:0] slot_code;
  logic [DW-1:0] slot_prefix;
  logic [7:0]    slot_suffix;
  logic          hit, empty, give_up, can_insert, grow;
  logic [NW-1:0] next_code_inc;
  logic [NW-1:0] width_pow;

  assign slot_valid  = ram_rdata[EW-1];
  assign slot_code   = ram_rdata[EW-2 -: DW];
  assign slot_prefix = ram_rdata[DW+7 -: DW];
  assign slot_suffix = ram_rdata[7:0];
  assign hit     = slot_valid && (slot_prefix == pending) && (slot_suffix == k_r);
  assign empty   = !slot_valid;
  assign give_up = slot_valid && !hit && (probe_cnt == HW'(HASH_SLOTS - 1));
  assign can_insert    = empty && (next_code < NW'(DICT_ENTRIES));
  assign next_code_inc = next_code + NW'(1);
  assign width_pow     = NW'(1) << code_width;
  assign grow = (next_code_inc == width_pow) && (width_pow < NW'(DICT_ENTRIES));

  logic accept;
  assign accept = in_valid && in_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      C_SWEEP: if (sweep_addr == HW'(HASH_SLOTS - 1)) state_next = C_IDLE;
      C_IDLE:  if (accept) state_next = started ? C_PROBE : C_CODE1;
      C_PROBE: begin
        if (hit) begin
          state_next = last_r ? C_CODE3 : C_DONE;
        end else if (empty || give_up) begin
          state_next = C_CODE1;
        end
      end
      C_CODE1: begin
        if (cmd_ready) begin
          if (need_clr) state_next = C_CODE2;
          else          state_next = last_r ? C_CODE3 : C_DONE;
        end
      end
      C_CODE2: if (cmd_ready) state_next = last_r ? C_CODE3 : C_DONE;
      C_CODE3: if (cmd_ready) state_next = C_CODE4;
      C_CODE4: if (cmd_ready) state_next = C_DONE;
      C_DONE:  if (cmd_ready) state_next = (last_r || need_sweep) ? C_SWEEP : C_IDLE;
      default: state_next = C_SWEEP;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready  = 1'b0;
    cmd_valid = 1'b0;
    cmd.kind  = KIND_CODE;
    cmd.code  = '0;
    cmd.width = code_width;
    cmd.last  = last_r;
    ram_we    = 1'b0;
    ram_waddr = probe_addr;
    ram_wdata = {1'b1, next_code[DW-1:0], pending, k_r};
    ram_raddr = hash0;
    unique case (state)
      C_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        ram_wdata = '0;
      end
      C_IDLE: in_ready = 1'b1;
      C_PROBE: begin
        ram_raddr = probe_addr + HW'(1);
        ram_we    = !hit && can_insert;
      end
      C_CODE1: begin
        cmd_valid = 1'b1;
        cmd.code  = CODE_W_MAX'(send_code);
        cmd.width = send_cw;
      end
      C_CODE2: begin
        cmd_valid = 1'b1;
        cmd.code  = CODE_W_MAX'(CODE_CLEAR);
        cmd.width = send_cw;
      end
      C_CODE3: begin
        cmd_valid = 1'b1;
        cmd.code  = CODE_W_MAX'(pending);
      end
      C_CODE4: begin
        cmd_valid = 1'b1;
        cmd.code  = CODE_W_MAX'(CODE_END);
      end
      C_DONE: begin
        cmd_valid = 1'b1;
        cmd.kind  = KIND_DONE;
      end
      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= C_SWEEP;
      sweep_addr <= '0;
      started    <= 1'b0;
      pending    <= '0;
      next_code  <= NW'(CODE_FIRST);
      code_width <= CW_W'(WIDTH_MIN);
      need_clr   <= 1'b0;
      need_sweep <= 1'b0;
      last_r     <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        C_SWEEP: sweep_addr <= sweep_addr + HW'(1);
        C_IDLE: begin
          if (accept) begin
            k_r        <= data_byte;
            last_r     <= final_byte;
            probe_addr <= hash0;
            probe_cnt  <= '0;
            need_clr   <= 1'b0;
            need_sweep <= 1'b0;
            if (!started) begin
              send_code <= DW'(CODE_CLEAR);
              send_cw   <= code_width;
              pending   <= DW'(data_byte);
              started   <= 1'b1;
            end
          end
        end
        C_PROBE: begin
          if (hit) begin
            pending <= slot_code;
          end else if (empty || give_up) begin
            send_code <= pending;
            send_cw   <= code_width;
            pending   <= DW'(k_r);
            if (can_insert) begin
              next_code <= next_code_inc;
              if (grow) code_width <= code_width + CW_W'(1);
            end else begin
              // Dictionary or hash full: clear code follows, then restart
              need_clr   <= 1'b1;
              need_sweep <= 1'b1;
              next_code  <= NW'(CODE_FIRST);
              code_width <= CW_W'(WIDTH_MIN);
            end
          end else begin
            probe_addr <= probe_addr + HW'(1);
            probe_cnt  <= probe_cnt + HW'(1);
          end
        end
        C_DONE: begin
          if (cmd_ready) begin
            sweep_addr <= '0;
            if (last_r) begin
              started    <= 1'b0;
              pending    <= '0;
              next_code  <= NW'(CODE_FIRST);
              code_width <= CW_W'(WIDTH_MIN);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/lzwc_packer.sv
// Bit packer: LSB-first code packing, one-byte hold for end-of-item marking,
// output register. Depends on lzwc_pkg.
`default_nettype none

module lzwc_packer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_ready,
  input  wire lzwc_pkg::pack_cmd_t cmd,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               code_byte,
  output logic                     run_end,
  output logic                     stream_end
);
  import lzwc_pkg::*;

  localparam int unsigned BW = 8 + CODE_W_MAX;

  pack_state_t state, state_next;

  logic [BW-1:0]   pack_buf;
  logic [CW_W-1:0] cnt;
  logic            done_r;
  logic            last_r;
  logic            hold_valid;
  logic [7:0]      hold_byte;

  logic out_free, want_push, can_move, accept, load_out;
  logic [CODE_W_MAX-1:0] masked;

  assign out_free  = !out_valid || out_ready;
  assign want_push = (cnt >= CW_W'(8)) || (done_r && last_r && (cnt != '0));
  assign can_move  = !hold_valid || out_free;
  assign accept    = cmd_valid && cmd_ready;
  assign masked    = cmd.code & ~({CODE_W_MAX{1'b1}} << cmd.width);

  // Output register loads from the hold stage
  assign load_out = hold_valid &&
                    (((state == P_PUSH) && want_push && can_move) ||
                     ((state == P_FLUSH) && out_free));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      P_IDLE:  if (accept) state_next = P_PUSH;
      P_PUSH:  if (!want_push) state_next = done_r ? P_FLUSH : P_IDLE;
      P_FLUSH: if (!hold_valid || out_free) state_next = P_IDLE;
      default: state_next = P_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_ready = 1'b0;
    unique case (state)
      P_IDLE:  cmd_ready = 1'b1;
      default: cmd_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= P_IDLE;
      pack_buf   <= '0;
      cnt        <= '0;
      done_r     <= 1'b0;
      last_r     <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        P_IDLE: begin
          if (accept) begin
            if (cmd.kind == KIND_CODE) begin
              pack_buf <= pack_buf | (BW'(masked) << cnt);
              cnt      <= cnt + cmd.width;
              done_r   <= 1'b0;
            end else begin
              done_r <= 1'b1;
              last_r <= cmd.last;
            end
          end
        end
        P_PUSH: begin
          // Move one byte into the hold stage; the previous one goes out
          if (want_push && can_move) begin
            if (hold_valid) begin
              code_byte  <= hold_byte;
              run_end    <= 1'b0;
              stream_end <= 1'b0;
            end
            hold_valid <= 1'b1;
            hold_byte  <= pack_buf[7:0];
            pack_buf   <= pack_buf >> 8;
            cnt        <= (cnt >= CW_W'(8)) ? cnt - CW_W'(8) : '0;
          end
        end
        P_FLUSH: begin
          // Last byte of this item gets the end marks
          if (!hold_valid || out_free) begin
            if (hold_valid) begin
              code_byte  <= hold_byte;
              run_end    <= 1'b1;
              stream_end <= last_r;
              hold_valid <= 1'b0;
            end
            if (last_r) begin
              pack_buf <= '0;
              cnt      <= '0;
            end
            done_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/lzwc_checker.sv
// Port-level checks for the LZW byte compressor, bound to the top level.
// No dependencies.
`default_nettype none

module lzwc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] code_byte,
  input wire logic       run_end,
  input wire logic       stream_end
);

  // The hash sweep follows reset, so no byte is taken right after it
  a_reset_busy: assert property (@(posedge clk) rst |=> !in_ready && !out_valid)
    else $error("input ready or output valid right after reset");

  // One byte in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("byte accepted while the previous one is in work");

  // The final stream byte also closes its item
  a_stream_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stream_end) |-> run_end)
    else $error("stream end without run end");

  // Stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(code_byte) && $stable(run_end))
    else $error("output item changed while stalled");

endmodule

bind lzw_byte_compressor lzwc_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .code_byte (code_byte),
  .run_end   (run_end),
  .stream_end(stream_end)
);

`default_nettype wire

>>> verif/tb_lzw_byte_compressor.sv
// Self-checking testbench for lzw_byte_compressor: random and directed byte streams
// are checked byte for byte against a behavioral LZW predictor.
// Depends on lzwc_pkg and the lzw_byte_compressor RTL.
`timescale 1ns / 100ps

module tb_lzw_byte_compressor;
  import lzwc_pkg::*;

  localparam int unsigned DICT_N = DICT_ENTRIES_DEF;
  localparam int unsigned SLOT_N = HASH_SLOTS_DEF;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         wait_drain;
  } byte_req_t;

  typedef struct {
    logic [7:0] code_byte;
    logic       run_end;
    logic       stream_end;
  } code_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       final_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] code_byte;
  logic       run_end;
  logic       stream_end;

  byte_req_t  byte_q[$];
  code_out_t  code_q[$];

  int unsigned n_bytes_in   = 0;
  int unsigned n_codes_seen = 0;
  int unsigned n_streams    = 0;
  int unsigned n_clears     = 0;
  int unsigned fails        = 0;
  bit          in_taken     = 1'b0;
  bit          in_stream    = 1'b0;
  bit          hold_done    = 1'b0;
  int unsigned hold_cnt     = 0;

  // Predictor state
  logic [11:0] lz_pend;
  bit          lz_started;
  int unsigned lz_next;
  int unsigned lz_width;
  int unsigned lz_buf;
  int unsigned lz_bits;
  logic [11:0] lz_prefix[DICT_N];
  logic [7:0]  lz_suffix[DICT_N];
  logic [12:0] lz_slot_code[SLOT_N];
  bit          lz_slot_ok[SLOT_N];
  code_out_t   lz_bytes[$];

  lzw_byte_compressor i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .final_byte(final_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_byte (code_byte),
    .run_end   (run_end),
    .stream_end(stream_end)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // LZW predictor
  // ---------------------------------------------------------------------------
  function automatic void lz_emit(int unsigned b);
    code_out_t c;
    if (lz_bytes.size() >= 7) return;
    c.code_byte  = b[7:0];
    c.run_end    = 1'b0;
    c.stream_end = 1'b0;
    lz_bytes = {lz_bytes, c};
  endfunction

  function automatic void lz_put(int unsigned code, int unsigned width);
    lz_buf  |= (code & ((32'd1 << width) - 1)) << lz_bits;
    lz_bits += width;
    while (lz_bits >= 8) begin
      lz_emit(lz_buf & 8'hFF);
      lz_buf  >>= 8;
      lz_bits -= 8;
    end
  endfunction

  function automatic void lz_restart();
    foreach (lz_slot_ok[i]) lz_slot_ok[i] = 1'b0;
    lz_next  = CODE_FIRST;
    lz_width = WIDTH_MIN;
  endfunction

  function automatic void lz_reset();
    lz_pend    = '0;
    lz_started = 1'b0;
    lz_buf     = 0;
    lz_bits    = 0;
    lz_restart();
  endfunction

  // Work out the code bytes caused by one input byte and queue them
  function automatic void lz_predict(logic [7:0] k, logic last);
    int unsigned h;
    int unsigned e;
    int unsigned n;
    int          found;
    int unsigned hit;
    int unsigned free_slot;
    lz_bytes.delete();
    if (!lz_started) begin
      lz_put(CODE_CLEAR, lz_width);
      lz_pend    = {4'h0, k};
      lz_started = 1'b1;
    end else begin
      // linear probe: 1 = match, 0 = empty slot, -1 = table full
      found = -1;
      h = ((int'(lz_pend) << 8) ^ k) & (SLOT_N - 1);
      for (n = 0; n < SLOT_N; n++) begin
        if (!lz_slot_ok[h]) begin
          free_slot = h;
          found = 0;
          break;
        end
        e = lz_slot_code[h] % DICT_N;
        if (lz_prefix[e] == lz_pend && lz_suffix[e] == k) begin
          hit = e;
          found = 1;
          break;
        end
        h = (h + 1) & (SLOT_N - 1);
      end
      if (found == 1) begin
        lz_pend = hit[11:0];
      end else begin
        lz_put(lz_pend, lz_width);
        if (found == 0 && lz_next <= DICT_N - 1) begin
          lz_prefix[lz_next]       = lz_pend;
          lz_suffix[lz_next]       = k;
          lz_slot_code[free_slot]  = lz_next[12:0];
          lz_slot_ok[free_slot]    = 1'b1;
          lz_next++;
          if (lz_next == (32'd1 << lz_width) && (32'd1 << lz_width) < DICT_N)
            lz_width++;
        end else begin
          // dictionary or hash table full: clear code and restart
          lz_put(CODE_CLEAR, lz_width);
          lz_restart();
          n_clears++;
        end
        lz_pend = {4'h0, k};
      end
    end
    if (last) begin
      lz_put(lz_pend, lz_width);
      lz_put(CODE_END, lz_width);
      if (lz_bits != 0) lz_emit(lz_buf & 8'hFF);
      if (lz_bytes.size() > 0) lz_bytes[lz_bytes.size()-1].stream_end = 1'b1;
      lz_reset();
    end
    if (lz_bytes.size() > 0) lz_bytes[lz_bytes.size()-1].run_end = 1'b1;
    foreach (lz_bytes[i]) code_q = {code_q, lz_bytes[i]};
  endfunction

  // ---------------------------------------------------------------------------
  // Idle rates by phase: sender busy first, then receiver, then none
  // ---------------------------------------------------------------------------
  function automatic int unsigned send_idle_pct();
    if (n_bytes_in < 110) return 22;
    if (n_bytes_in < 220) return 65;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (n_bytes_in < 110) return 65;
    if (n_bytes_in < 220) return 22;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample both handshakes at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    code_out_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        lz_predict(data_byte, final_byte);
        n_bytes_in++;
        if (final_byte) n_streams++;
        in_stream = !final_byte;
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        n_codes_seen++;
        if (code_q.size() == 0) begin
          $error("unexpected code byte 0x%02h", code_byte);
          fails++;
        end else begin
          want = code_q.pop_front();
          if (code_byte !== want.code_byte) begin
            $error("code_byte: expected 0x%02h, got 0x%02h", want.code_byte, code_byte);
            fails++;
          end
          if (run_end !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, run_end);
            fails++;
          end
          if (stream_end !== want.stream_end) begin
            $error("stream_end: expected %0b, got %0b", want.stream_end, stream_end);
            fails++;
          end
        end
      end
    end
  end

  // Driver: one item in flight, fed from byte_q
  always @(negedge clk) begin
    logic       nv;
    logic [7:0] nd;
    logic       nf;
    byte_req_t  r;
    nv = in_valid;
    nd = data_byte;
    nf = final_byte;
    if (!rst) begin
      if (!in_valid || in_taken) begin
        nv = 1'b0;
        if (byte_q.size() > 0 && !(byte_q[0].wait_drain && code_q.size() > 0) &&
            $urandom_range(99) >= send_idle_pct()) begin
          r  = byte_q.pop_front();
          nv = 1'b1;
          nd = r.data;
          nf = r.last;
        end
      end
      in_taken = 1'b0;
    end
    in_valid   <= nv;
    data_byte  <= nd;
    final_byte <= nf;
  end

  // Receiver: random stalls plus one long hold-off in the middle of a stream
  always @(negedge clk) begin
    logic nr;
    nr = 1'b0;
    if (!rst) begin
      if (!hold_done && n_codes_seen >= 100 && in_stream) begin
        hold_done = 1'b1;
        hold_cnt  = 400;
      end
      if (hold_cnt > 0) hold_cnt--;
      else nr = ($urandom_range(99) >= recv_idle_pct());
    end
    out_ready <= nr;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_byte(logic [7:0] d, logic last, bit drain = 1'b0);
    byte_req_t r;
    r.data = d;
    r.last = last;
    r.wait_drain = drain;
    byte_q = {byte_q, r};
  endtask

  // style 0: any byte, 1: two-symbol alphabet (many hits), 2: repeated byte
  task automatic add_stream(int unsigned len, int unsigned style);
    logic [7:0] d;
    logic [7:0] rep;
    rep = 8'($urandom_range(255));
    for (int unsigned i = 0; i < len; i++) begin
      case (style)
        0: d = 8'($urandom_range(255));
        1: d = $urandom_range(1) ? 8'hFF : 8'h00;
        default: d = rep;
      endcase
      add_byte(d, i == len - 1);
    end
  endtask

  initial begin
    int unsigned budget;
    int unsigned len;
    lz_reset();
    // directed: one-byte streams at the extremes, repeats that hit, mixed bits
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h41, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'h41, 1'b1);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h55, 1'b1);
    add_byte(8'h00, 1'b0, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    // random streams, mostly short
    budget = 313;
    while (budget > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
      if (len > budget) len = budget;
      add_stream(len, $urandom_range(2));
      budget -= len;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (byte_q.size() > 0 || in_valid) @(posedge clk);
    while (code_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    #1;

    $display("Compressed %0d bytes in %0d streams, %0d dictionary restarts;",
             n_bytes_in, n_streams, n_clears);
    $display("checked %0d code bytes with idle, stall and hold-off phases.", n_codes_seen);
    if (fails == 0 && code_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> lzw_byte_compressor.f
hdl/lzwc_pkg.sv
hdl/lzwc_hash_ram.sv
hdl/lzwc_ctrl.sv
hdl/lzwc_packer.sv
hdl/lzw_byte_compressor.sv
hdl/lzwc_checker.sv
verif/tb_lzw_byte_compressor.sv
